// ===== sv/dhad_pkg.sv =====
// Shared types and constants for the two-channel arrival difference block.
// Used by dhad_core and by the top level dual_hydrophone_arrival_difference.
package dhad_pkg;

  // Field and counter widths.
  localparam int QUIET_W = 20;
  localparam int WIN_W   = 14;
  localparam int IDX_W   = 13;
  localparam int DIFF_W  = 14;
  localparam int ERR_W   = 2;

  // Largest capture window in samples.
  localparam logic [WIN_W-1:0] MAX_WINDOW = WIN_W'(8192);

  // Saturation value of the quiet counter.
  localparam logic [QUIET_W-1:0] QUIET_MAX = '1;

  // Register reset values.
  localparam logic [QUIET_W-1:0] QUIET_RESET  = QUIET_W'(300000);
  localparam logic [WIN_W-1:0]   WIN_RESET    = WIN_W'(8000);
  localparam logic [IDX_W-1:0]   MAXD_RESET   = IDX_W'(200);

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_QUIET_TICKS    = 2'd0;
  localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd1;
  localparam logic [1:0] REG_MAX_DIFFERENCE = 2'd2;

  // Result error codes.
  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BETWEEN = 2'd1;
  localparam logic [ERR_W-1:0] ERR_MISS    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd3;

  // Capture phases.
  localparam logic PH_QUIET   = 1'b0;
  localparam logic PH_CAPTURE = 1'b1;

  // Configuration registers as seen by the core.
  typedef struct packed {
    logic [QUIET_W-1:0] quiet_ticks;
    logic [WIN_W-1:0]   window_length;
    logic [IDX_W-1:0]   max_difference;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [DIFF_W-1:0] arrival_difference;
    logic [ERR_W-1:0]  error_code;
  } result_t;

endpackage

// ===== sv/dhad_core.sv =====
// Quiet-wait and capture-window state for the arrival difference block.
// Depends on dhad_pkg; advances one sample per accepted item.
module dhad_core (
  input  logic              clk,
  input  logic              rst,
  input  dhad_pkg::cfg_t    cfg,
  input  logic              step,
  input  logic              trip_a,
  input  logic              trip_b,
  output logic              res_valid,
  output dhad_pkg::result_t res
);

  logic                         phase, phase_next;
  logic [dhad_pkg::QUIET_W-1:0] quiet_count, quiet_count_next;
  logic [dhad_pkg::IDX_W-1:0]   sample_index, sample_index_next;
  logic                         latched_a, latched_a_next;
  logic                         latched_b, latched_b_next;
  logic [dhad_pkg::IDX_W-1:0]   first_index_a, first_index_a_next;
  logic [dhad_pkg::IDX_W-1:0]   first_index_b, first_index_b_next;
  logic                         found_a, found_a_next;
  logic                         found_b, found_b_next;
  logic                         start_tripped, start_tripped_next;

  logic [dhad_pkg::QUIET_W-1:0] quiet_need;
  logic [dhad_pkg::QUIET_W-1:0] quiet_inc;
  logic [dhad_pkg::WIN_W-1:0]   win_eff;
  logic [dhad_pkg::WIN_W-1:0]   index_plus;
  logic                         window_done;
  logic signed [dhad_pkg::DIFF_W-1:0] diff;
  logic [dhad_pkg::DIFF_W-1:0]  mag;

  // Effective register values after clamping.
  always_comb begin
    quiet_need = (cfg.quiet_ticks == '0) ? dhad_pkg::QUIET_W'(1) : cfg.quiet_ticks;
    if (cfg.window_length == '0) begin
      win_eff = dhad_pkg::WIN_W'(1);
    end else if (cfg.window_length > dhad_pkg::MAX_WINDOW) begin
      win_eff = dhad_pkg::MAX_WINDOW;
    end else begin
      win_eff = cfg.window_length;
    end
    quiet_inc  = (quiet_count == dhad_pkg::QUIET_MAX) ? quiet_count : quiet_count + 1'b1;
    index_plus = {1'b0, sample_index} + dhad_pkg::WIN_W'(1);
    window_done = (index_plus >= win_eff);
  end

  // Next state for one sample, plus the result when a window closes with a trip.
  always_comb begin
    phase_next         = phase;
    quiet_count_next   = quiet_count;
    sample_index_next  = sample_index;
    latched_a_next     = latched_a;
    latched_b_next     = latched_b;
    first_index_a_next = first_index_a;
    first_index_b_next = first_index_b;
    found_a_next       = found_a;
    found_b_next       = found_b;
    start_tripped_next = start_tripped;
    res_valid          = 1'b0;
    diff               = '0;
    mag                = '0;
    res.error_code         = dhad_pkg::ERR_NONE;
    res.arrival_difference = '0;

    if (step) begin
      if (phase == dhad_pkg::PH_QUIET) begin
        // Count trip-free samples; any trip restarts the count.
        if (trip_a || trip_b) begin
          quiet_count_next = '0;
        end else if (quiet_inc >= quiet_need) begin
          phase_next         = dhad_pkg::PH_CAPTURE;
          quiet_count_next   = '0;
          sample_index_next  = '0;
          latched_a_next     = 1'b0;
          latched_b_next     = 1'b0;
          first_index_a_next = '0;
          first_index_b_next = '0;
          found_a_next       = 1'b0;
          found_b_next       = 1'b0;
          start_tripped_next = 1'b0;
        end else begin
          quiet_count_next = quiet_inc;
        end
      end else begin
        // Latch trips and record the first index at which each latch is set.
        latched_a_next = latched_a | trip_a;
        latched_b_next = latched_b | trip_b;
        if (sample_index == '0) begin
          start_tripped_next = start_tripped | latched_a_next | latched_b_next;
        end else begin
          if (latched_a_next && !found_a) begin
            found_a_next       = 1'b1;
            first_index_a_next = sample_index;
          end
          if (latched_b_next && !found_b) begin
            found_b_next       = 1'b1;
            first_index_b_next = sample_index;
          end
        end

        // Evaluate the window outcome from the updated capture state.
        diff = $signed({1'b0, first_index_b_next}) - $signed({1'b0, first_index_a_next});
        mag  = diff[dhad_pkg::DIFF_W-1] ? dhad_pkg::DIFF_W'(-diff) : dhad_pkg::DIFF_W'(diff);

        if (!window_done) begin
          sample_index_next = sample_index + 1'b1;
        end else begin
          if (latched_a_next || latched_b_next) begin
            res_valid = 1'b1;
            if (start_tripped_next) begin
              res.error_code = dhad_pkg::ERR_BETWEEN;
            end else if (!found_a_next || !found_b_next) begin
              res.error_code = dhad_pkg::ERR_MISS;
            end else begin
              res.arrival_difference = diff;
              res.error_code = (mag > {1'b0, cfg.max_difference}) ?
                               dhad_pkg::ERR_RANGE : dhad_pkg::ERR_NONE;
            end
            phase_next       = dhad_pkg::PH_QUIET;
            quiet_count_next = '0;
          end
          // Either way the capture state starts over.
          sample_index_next  = '0;
          latched_a_next     = 1'b0;
          latched_b_next     = 1'b0;
          first_index_a_next = '0;
          first_index_b_next = '0;
          found_a_next       = 1'b0;
          found_b_next       = 1'b0;
          start_tripped_next = 1'b0;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dhad_pkg::PH_QUIET;
      quiet_count   <= '0;
      sample_index  <= '0;
      latched_a     <= 1'b0;
      latched_b     <= 1'b0;
      first_index_a <= '0;
      first_index_b <= '0;
      found_a       <= 1'b0;
      found_b       <= 1'b0;
      start_tripped <= 1'b0;
    end else begin
      phase         <= phase_next;
      quiet_count   <= quiet_count_next;
      sample_index  <= sample_index_next;
      latched_a     <= latched_a_next;
      latched_b     <= latched_b_next;
      first_index_a <= first_index_a_next;
      first_index_b <= first_index_b_next;
      found_a       <= found_a_next;
      found_b       <= found_b_next;
      start_tripped <= start_tripped_next;
    end
  end

endmodule

// ===== sv/dual_hydrophone_arrival_difference.sv =====
// Top level of the two-channel arrival difference block: configuration
// registers, input stream, output register. Depends on dhad_pkg and dhad_core.

// Each input item is one sample holding a trip bit per hydrophone. The block
// waits for quiet_ticks trip-free samples, then captures windows of
// window_length samples until a window ends with a trip, and then emits one
// result: the first trip index of channel b minus that of channel a, with an
// error code. The block takes one item per clock cycle; a result appears on
// the output register the cycle after the item that closes its window is
// accepted. The one-entry output register sets the rate under backpressure:
// input is taken whenever that register is empty or being drained.
module dual_hydrophone_arrival_difference (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] trip_a, [1] trip_b, [7:2] zero
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] error_code, [15:2] arrival_difference
);

  dhad_pkg::cfg_t    cfg;
  dhad_pkg::result_t res;
  dhad_pkg::result_t out_reg;
  logic              res_valid;
  logic              step;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quiet_ticks    <= dhad_pkg::QUIET_RESET;
      cfg.window_length  <= dhad_pkg::WIN_RESET;
      cfg.max_difference <= dhad_pkg::MAXD_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        dhad_pkg::REG_QUIET_TICKS:    cfg.quiet_ticks    <= pwdata[dhad_pkg::QUIET_W-1:0];
        dhad_pkg::REG_WINDOW_LENGTH:  cfg.window_length  <= pwdata[dhad_pkg::WIN_W-1:0];
        dhad_pkg::REG_MAX_DIFFERENCE: cfg.max_difference <= pwdata[dhad_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      dhad_pkg::REG_QUIET_TICKS:    prdata = 32'(cfg.quiet_ticks);
      dhad_pkg::REG_WINDOW_LENGTH:  prdata = 32'(cfg.window_length);
      dhad_pkg::REG_MAX_DIFFERENCE: prdata = 32'(cfg.max_difference);
      default:                      prdata = '0;
    endcase
  end

  // An item is taken whenever the output register is free or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  dhad_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .trip_a    (s_tdata[0]),
    .trip_b    (s_tdata[1]),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_reg <= res;
    end
  end

  assign m_tdata = out_reg;

endmodule

// ===== tb/tb_dual_hydrophone_arrival_difference.sv =====
// Self-checking testbench for dual_hydrophone_arrival_difference: a local copy of the
// detector predicts each result item, which is compared against the result stream.
// Depends on dhad_pkg and the RTL of the block; needs no files or arguments.
module tb_dual_hydrophone_arrival_difference;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [0] trip_a, [1] trip_b, [7:2] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // [1:0] error_code, [15:2] arrival_difference

  dual_hydrophone_arrival_difference dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local detector state and register copies.
  logic [dhad_pkg::QUIET_W-1:0] cfg_quiet = dhad_pkg::QUIET_RESET;
  logic [dhad_pkg::WIN_W-1:0]   cfg_win   = dhad_pkg::WIN_RESET;
  logic [dhad_pkg::IDX_W-1:0]   cfg_maxd  = dhad_pkg::MAXD_RESET;
  logic                         ph        = dhad_pkg::PH_QUIET;
  logic [dhad_pkg::QUIET_W-1:0] q_cnt     = '0;
  logic [dhad_pkg::IDX_W-1:0]   idx       = '0;
  logic [dhad_pkg::IDX_W-1:0]   first_a   = '0;
  logic [dhad_pkg::IDX_W-1:0]   first_b   = '0;
  logic lat_a = 1'b0, lat_b = 1'b0, fnd_a = 1'b0, fnd_b = 1'b0, tripped0 = 1'b0;

  dhad_pkg::result_t awaited_reports[$];
  int  mismatches = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;

  // Effective window length after clamping.
  function automatic int window_span();
    int s;
    s = int'(cfg_win);
    if (s < 1) s = 1;
    if (s > int'(dhad_pkg::MAX_WINDOW)) s = int'(dhad_pkg::MAX_WINDOW);
    return s;
  endfunction

  function automatic void clear_capture();
    idx = '0;
    lat_a = 1'b0;
    lat_b = 1'b0;
    first_a = '0;
    first_b = '0;
    fnd_a = 1'b0;
    fnd_b = 1'b0;
    tripped0 = 1'b0;
  endfunction

  // Advance the detector by one accepted sample; queue a result when a window closes.
  function automatic void advance_detector(input logic ta, input logic tb);
    int need, diff, mag;
    dhad_pkg::result_t r;
    if (ph == dhad_pkg::PH_QUIET) begin
      need = (cfg_quiet == '0) ? 1 : int'(cfg_quiet);
      if (ta || tb) begin
        q_cnt = '0;
      end else begin
        if (q_cnt != dhad_pkg::QUIET_MAX) q_cnt++;
        if (int'(q_cnt) >= need) begin
          ph = dhad_pkg::PH_CAPTURE;
          q_cnt = '0;
          clear_capture();
        end
      end
      return;
    end
    if (ta) lat_a = 1'b1;
    if (tb) lat_b = 1'b1;
    if (idx == '0) begin
      if (lat_a || lat_b) tripped0 = 1'b1;
    end else begin
      if (lat_a && !fnd_a) begin
        fnd_a = 1'b1;
        first_a = idx;
      end
      if (lat_b && !fnd_b) begin
        fnd_b = 1'b1;
        first_b = idx;
      end
    end
    if (int'(idx) + 1 < window_span()) begin
      idx++;
      return;
    end
    // A window with no trip at all just starts the next one.
    if (!(lat_a || lat_b)) begin
      clear_capture();
      return;
    end
    diff = 0;
    if (tripped0) begin
      r.error_code = dhad_pkg::ERR_BETWEEN;
    end else if (!fnd_a || !fnd_b) begin
      r.error_code = dhad_pkg::ERR_MISS;
    end else begin
      diff = int'(first_b) - int'(first_a);
      mag = (diff < 0) ? -diff : diff;
      r.error_code = (mag > int'(cfg_maxd)) ? dhad_pkg::ERR_RANGE : dhad_pkg::ERR_NONE;
    end
    r.arrival_difference = dhad_pkg::DIFF_W'(diff);
    awaited_reports.push_back(r);
    ph = dhad_pkg::PH_QUIET;
    q_cnt = '0;
    clear_capture();
  endfunction

  // Offer one sample, with random idle cycles in front unless calm is set, and predict once it is taken.
  task automatic send_sample(input logic ta, input logic tb);
    while (!calm && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, tb, ta};
    do @(posedge clk); while (!s_tready);
    advance_detector(ta, tb);
  endtask

  // Stop offering items and wait until every predicted result has been seen.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: a setup phase, then the access phase until pready, then an idle phase.
  task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      dhad_pkg::REG_QUIET_TICKS:    cfg_quiet = value[dhad_pkg::QUIET_W-1:0];
      dhad_pkg::REG_WINDOW_LENGTH:  cfg_win = value[dhad_pkg::WIN_W-1:0];
      dhad_pkg::REG_MAX_DIFFERENCE: cfg_maxd = value[dhad_pkg::IDX_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int quiet, input int win, input int maxd);
    settle();
    write_reg(dhad_pkg::REG_QUIET_TICKS, quiet);
    write_reg(dhad_pkg::REG_WINDOW_LENGTH, win);
    write_reg(dhad_pkg::REG_MAX_DIFFERENCE, maxd);
  endtask

  // Sit out the quiet wait, then send one window with each channel tripping
  // first at the given index (-1 means the channel stays silent).
  task automatic send_window(input int at_a, input int at_b);
    int span;
    while (ph == dhad_pkg::PH_QUIET) send_sample(1'b0, 1'b0);
    span = window_span();
    for (int i = 0; i < span; i++) send_sample(i == at_a, i == at_b);
  endtask

  // Mostly well-formed traffic: quiet runs with rare noise, then windows with
  // planned first-trip indices, some missing, some at the first sample.
  task automatic run_traffic(input int n_items);
    int plan_a, plan_b, span, pick;
    logic ta, tb;
    plan_a = -1;
    plan_b = -1;
    repeat (n_items) begin
      if (ph == dhad_pkg::PH_QUIET) begin
        ta = ($urandom_range(99) < 2);
        tb = ($urandom_range(99) < 2);
      end else begin
        if (idx == '0) begin
          span = window_span();
          pick = $urandom_range(99);
          plan_a = (pick < 15) ? -1 : (pick < 20 || span < 2) ? 0 : $urandom_range(1, span - 1);
          pick = $urandom_range(99);
          plan_b = (pick < 15) ? -1 : (pick < 20 || span < 2) ? 0 : $urandom_range(1, span - 1);
          if ($urandom_range(9) == 0) begin
            plan_a = -1;
            plan_b = -1;
          end
        end
        ta = (int'(idx) == plan_a) ||
             (plan_a >= 0 && int'(idx) > plan_a && $urandom_range(3) == 0);
        tb = (int'(idx) == plan_b) ||
             (plan_b >= 0 && int'(idx) > plan_b && $urandom_range(3) == 0);
      end
      send_sample(ta, tb);
    end
  endtask

  // Each error kind but ERR_RANGE, both signs of the difference, zero quiet ticks, empty window.
  task automatic test_basic_cases();
    set_config(0, 3, 8191);
    send_window(1, 2);
    send_window(2, 1);
    send_window(1, 1);
    send_window(0, 2);
    send_window(1, -1);
    send_window(-1, 2);
    send_window(-1, -1);
    send_window(2, 2);
  endtask

  // Register extremes: out-of-range limit, one-sample windows, largest quiet count,
  // and a trip that restarts the quiet count.
  task automatic test_register_extremes();
    set_config(1, 3, 0);
    send_window(1, 2);
    set_config(1, 0, 8191);
    send_window(0, 0);
    set_config(1, 1, 8191);
    send_window(-1, 0);
    set_config(1, 2, 8191);
    send_window(1, 1);
    set_config(1048575, 2, 8191);
    repeat (5) send_sample(1'b0, 1'b0);
    set_config(3, 2, 8191);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    send_window(-1, 1);
  endtask

  // Long windows, giving wide differences of both signs.
  task automatic test_wide_window();
    set_config(1, 300, 8191);
    send_window(1, 299);
    set_config(1, 300, 297);
    send_window(299, 1);
  endtask

  // Shrinking the window below the current index closes it at the next sample.
  task automatic test_window_shrink();
    set_config(1, 50, 8191);
    while (ph == dhad_pkg::PH_QUIET) send_sample(1'b0, 1'b0);
    for (int i = 0; i < 10; i++) send_sample(i == 3, i == 5);
    settle();
    write_reg(dhad_pkg::REG_WINDOW_LENGTH, 4);
    send_sample(1'b0, 1'b0);
  endtask

  // Result receiver holds off while short windows keep producing results.
  task automatic test_backpressure();
    set_config(1, 4, 2);
    hold_requests++;
    run_traffic(200);
  endtask

  task automatic test_random_traffic();
    set_config(1, 2, 0);
    run_traffic(120);
    set_config(4, 12, 5);
    run_traffic(120);
    calm = 1'b1;
    set_config(2, 30, 20);
    run_traffic(150);
    calm = 1'b0;
    set_config(0, 6, 8191);
    run_traffic(120);
    repeat (2) begin
      set_config($urandom_range(1, 8), $urandom_range(2, 40), $urandom_range(0, 30));
      run_traffic(120);
    end
  endtask

  // Result receiver: compare each taken result item, then pick the next tready.
  always @(posedge clk) begin
    dhad_pkg::result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = dhad_pkg::result_t'(m_tdata);
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual err=%0d diff=%0d",
                   $time, got.error_code, $signed(got.arrival_difference));
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          if (got.error_code !== want.error_code) begin
            $display("%0t: error_code mismatch: expected %0d, actual %0d",
                     $time, want.error_code, got.error_code);
            mismatches++;
          end
          if (got.arrival_difference !== want.arrival_difference) begin
            $display("%0t: arrival_difference mismatch: expected %0d, actual %0d", $time,
                     $signed(want.arrival_difference), $signed(got.arrival_difference));
            mismatches++;
          end
        end
      end
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_cases();
    test_register_extremes();
    test_window_shrink();
    test_wide_window();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dhad_pkg.sv
sv/dhad_core.sv
sv/dual_hydrophone_arrival_difference.sv
tb/tb_dual_hydrophone_arrival_difference.sv
